FILE: sv/pafu_pkg.sv
// ----------------------------------------------------------------------------
// pafu_pkg: shared types and constants of the proxy address filter table
// Command and result words, filter type codes, decoded job format.
// ----------------------------------------------------------------------------
package pafu_pkg;

	// default sizes
	localparam int FILTER_SLOTS_DEF = 16;
	localparam int CLIENT_COUNT_DEF = 4;

	// command queue depth between front and back (power of two)
	localparam int QUEUE_DEPTH = 2;

	// field widths
	localparam int ADDR_W  = 16;
	localparam int MASK_W  = 4;
	localparam int ENTRY_W = 5;
	localparam int ENTRY_MAX = 31;

	localparam logic [ADDR_W-1:0] ALL_NODES = 16'hFFFF;

	// command codes
	localparam logic [2:0] CMD_SET        = 3'd0;
	localparam logic [2:0] CMD_ADD        = 3'd1;
	localparam logic [2:0] CMD_REMOVE     = 3'd2;
	localparam logic [2:0] CMD_MATCH      = 3'd3;
	localparam logic [2:0] CMD_LEARN      = 3'd4;
	localparam logic [2:0] CMD_CONNECT    = 3'd5;
	localparam logic [2:0] CMD_DISCONNECT = 3'd6;
	localparam logic [2:0] CMD_NOTIFY     = 3'd7;

	// type byte codes for set
	localparam logic [7:0] TB_ACCEPT = 8'h00;
	localparam logic [7:0] TB_REJECT = 8'h01;

	// filter type of a client
	typedef enum logic [1:0] {
		FT_NONE   = 2'd0,
		FT_ACCEPT = 2'd1,
		FT_REJECT = 2'd2
	} ftype_t;

	// decoded operation carried through the queue
	typedef enum logic [3:0] {
		OP_NOP,
		OP_PROHIBITED,
		OP_SET_ACC,
		OP_SET_REJ,
		OP_ADD,
		OP_REMOVE,
		OP_LEARN,
		OP_MATCH,
		OP_CONNECT,
		OP_DISCONNECT,
		OP_NOTIFY
	} op_t;

	// input word
	typedef struct packed {
		logic [2:0]        cmd;
		logic [1:0]        client_index;
		logic [ADDR_W-1:0] address;
		logic [7:0]        type_byte;
	} cmd_word_t;

	// result word
	typedef struct packed {
		logic [MASK_W-1:0]  match_mask;
		logic               status_type;
		logic [ENTRY_W-1:0] entry_count;
		logic               prohibited_type;
		logic               beacons_due;
	} result_t;

	// decoded job
	typedef struct packed {
		op_t               op;
		logic [1:0]        client_index;
		logic              client_ok;
		logic [ADDR_W-1:0] address;
	} job_t;

	// queue head offered to the back end
	typedef struct packed {
		logic valid;
		job_t job;
	} job_if_t;

endpackage

FILE: sv/pafu_front.sv
// ----------------------------------------------------------------------------
// pafu_front: command intake and decode
// Takes command words, classifies them into jobs and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module pafu_front
	import pafu_pkg::*;
#(
	parameter int CLIENT_COUNT = CLIENT_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cmd_word_t command,
	output logic      busy,
	output job_if_t   head,
	input  logic      take
);

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	job_t            queue_q [QUEUE_DEPTH];
	logic [QW-1:0]   wr_ptr_q;
	logic [QW-1:0]   rd_ptr_q;
	logic [QW:0]     count_q;
	logic            push;
	logic            pop;
	logic            ok;
	job_t            job;

	// classify the incoming word
	always_comb begin
		ok = (int'(command.client_index) < CLIENT_COUNT);
		job.client_index = command.client_index;
		job.client_ok    = ok;
		job.address      = command.address;
		job.op           = OP_NOP;
		unique case (command.cmd)
			CMD_SET: begin
				if (command.type_byte == TB_ACCEPT)
					job.op = ok ? OP_SET_ACC : OP_NOP;
				else if (command.type_byte == TB_REJECT)
					job.op = ok ? OP_SET_REJ : OP_NOP;
				else
					job.op = OP_PROHIBITED;
			end
			CMD_MATCH:      job.op = OP_MATCH;
			CMD_ADD:        job.op = ok ? OP_ADD : OP_NOP;
			CMD_REMOVE:     job.op = ok ? OP_REMOVE : OP_NOP;
			CMD_LEARN:      job.op = ok ? OP_LEARN : OP_NOP;
			CMD_CONNECT:    job.op = ok ? OP_CONNECT : OP_NOP;
			CMD_DISCONNECT: job.op = ok ? OP_DISCONNECT : OP_NOP;
			CMD_NOTIFY:     job.op = ok ? OP_NOTIFY : OP_NOP;
			default:        job.op = OP_NOP;
		endcase
	end

	assign busy = (count_q == (QW+1)'(QUEUE_DEPTH));
	assign push = start && !busy;
	assign pop  = take && head.valid;

	assign head.valid = (count_q != '0);
	assign head.job   = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= job;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: sv/pafu_back.sv
// ----------------------------------------------------------------------------
// pafu_back: filter table execution
// Holds the address tables and client state, walks the slots of all clients
// one slot per cycle for add, remove and relay match, and issues results.
// ----------------------------------------------------------------------------
module pafu_back
	import pafu_pkg::*;
#(
	parameter int FILTER_SLOTS = FILTER_SLOTS_DEF,
	parameter int CLIENT_COUNT = CLIENT_COUNT_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  job_if_t head,
	output logic    take,
	output logic    done,
	output result_t result
);

	localparam int SW = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
	localparam int CW = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;
	localparam int KW = $clog2(FILTER_SLOTS + 1);
	localparam int ML = (CLIENT_COUNT < MASK_W) ? CLIENT_COUNT : MASK_W;
	localparam logic [SW-1:0] LAST_SLOT = SW'(FILTER_SLOTS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// one row per slot, one lane per client
	logic [CLIENT_COUNT-1:0][ADDR_W-1:0] mem [FILTER_SLOTS];
	logic [CLIENT_COUNT-1:0][ADDR_W-1:0] rd_data_s1;

	state_t              state_q;
	job_t                job_q;
	logic [SW-1:0]       issue_q;
	logic                rd_pend_s1;
	logic [SW-1:0]       slot_s1;
	logic [CLIENT_COUNT-1:0] present_q;
	logic                found_q;
	logic [SW-1:0]       found_slot_q;
	logic                free_q;
	logic [SW-1:0]       free_slot_q;

	logic [FILTER_SLOTS-1:0] valid_q [CLIENT_COUNT];
	ftype_t              type_q  [CLIENT_COUNT];
	logic [KW-1:0]       count_q [CLIENT_COUNT];
	logic [CLIENT_COUNT-1:0] conn_q;

	logic [CW-1:0]       lane;
	logic [CW-1:0]       head_lane;
	logic [CLIENT_COUNT-1:0] hit_lane;
	logic [CLIENT_COUNT-1:0] pass;
	ftype_t              cur_type;
	logic [KW-1:0]       cur_count;
	ftype_t              nx_type;
	logic [KW-1:0]       nx_count;
	logic                add_en;
	logic                rem_en;
	logic                clear_row;
	logic                beacons;
	logic [MASK_W-1:0]   mask;
	logic [KW+4:0]       count_wide;
	logic [ENTRY_W-1:0]  count_sat;
	logic                need_walk;
	op_t                 take_op;
	job_t                take_job;

	assign lane      = CW'(job_q.client_index);
	assign head_lane = CW'(head.job.client_index);
	assign take      = (state_q == ST_IDLE) && head.valid;

	// learn turns into add or remove by the type in force when it runs
	always_comb begin
		take_op = head.job.op;
		if (head.job.op == OP_LEARN) begin
			if (type_q[head_lane] == FT_ACCEPT)
				take_op = OP_ADD;
			else if (type_q[head_lane] == FT_REJECT)
				take_op = OP_REMOVE;
			else
				take_op = OP_NOP;
		end
		need_walk = (take_op == OP_ADD) || (take_op == OP_REMOVE) || (take_op == OP_MATCH);
		take_job    = head.job;
		take_job.op = take_op;
	end

	// slot compare, all lanes at once
	always_comb begin
		for (int l = 0; l < CLIENT_COUNT; l++)
			hit_lane[l] = rd_pend_s1 && valid_q[l][slot_s1] &&
				(rd_data_s1[l] == job_q.address) && (job_q.address != '0);
	end

	// relay match decision per client
	always_comb begin
		for (int l = 0; l < CLIENT_COUNT; l++) begin
			if (type_q[l] == FT_REJECT)
				pass[l] = conn_q[l] && !present_q[l];
			else if (job_q.address == ALL_NODES)
				pass[l] = conn_q[l];
			else if (type_q[l] == FT_ACCEPT)
				pass[l] = conn_q[l] && present_q[l];
			else
				pass[l] = 1'b0;
		end
		mask = '0;
		for (int l = 0; l < ML; l++)
			mask[l] = pass[l];
	end

	// final update of the addressed client
	always_comb begin
		cur_type  = type_q[lane];
		cur_count = count_q[lane];
		nx_type   = cur_type;
		nx_count  = cur_count;
		add_en    = 1'b0;
		rem_en    = 1'b0;
		clear_row = 1'b0;
		beacons   = 1'b0;
		unique case (job_q.op)
			OP_SET_ACC: begin
				clear_row = 1'b1;
				nx_type   = FT_ACCEPT;
				nx_count  = '0;
			end
			OP_SET_REJ: begin
				clear_row = 1'b1;
				nx_type   = FT_REJECT;
				nx_count  = '0;
			end
			OP_ADD: begin
				if (job_q.address != '0 && !found_q && free_q) begin
					add_en   = 1'b1;
					nx_count = cur_count + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (found_q) begin
					rem_en   = 1'b1;
					nx_count = cur_count - 1'b1;
				end
			end
			OP_CONNECT: begin
				clear_row = 1'b1;
				nx_type   = FT_NONE;
				nx_count  = '0;
			end
			OP_NOTIFY: begin
				if (cur_type == FT_NONE) begin
					nx_type = FT_ACCEPT;
					beacons = 1'b1;
				end
			end
			default: ;
		endcase
		count_wide = (KW+5)'(nx_count);
		count_sat  = (count_wide > (KW+5)'(ENTRY_MAX)) ? ENTRY_W'(ENTRY_MAX)
			: count_wide[ENTRY_W-1:0];
	end

	// table memory: one row read per walk cycle, one lane written on add
	always_ff @(posedge clk) begin
		if (state_q == ST_WALK)
			rd_data_s1 <= mem[issue_q];
		if (state_q == ST_FINISH && add_en)
			mem[free_slot_q][lane] <= job_q.address;
	end

	// sequencer, client state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			job_q        <= '0;
			issue_q      <= '0;
			rd_pend_s1   <= 1'b0;
			slot_s1      <= '0;
			present_q    <= '0;
			found_q      <= 1'b0;
			found_slot_q <= '0;
			free_q       <= 1'b0;
			free_slot_q  <= '0;
			conn_q       <= '0;
			for (int c = 0; c < CLIENT_COUNT; c++) begin
				valid_q[c] <= '0;
				type_q[c]  <= FT_NONE;
				count_q[c] <= '0;
			end
			done   <= 1'b0;
			result <= '0;
		end else begin
			done <= 1'b0;

			// walk bookkeeping
			if (rd_pend_s1) begin
				present_q <= present_q | hit_lane;
				if (job_q.client_ok && !found_q && hit_lane[lane]) begin
					found_q      <= 1'b1;
					found_slot_q <= slot_s1;
				end
				if (job_q.client_ok && !free_q && !valid_q[lane][slot_s1]) begin
					free_q      <= 1'b1;
					free_slot_q <= slot_s1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						job_q     <= take_job;
						issue_q   <= '0;
						present_q <= '0;
						found_q   <= 1'b0;
						free_q    <= 1'b0;
						state_q   <= need_walk ? ST_WALK : ST_FINISH;
					end
				end
				ST_WALK: begin
					rd_pend_s1 <= 1'b1;
					slot_s1    <= issue_q;
					if (issue_q == LAST_SLOT)
						state_q <= ST_DRAIN;
					else
						issue_q <= issue_q + 1'b1;
				end
				ST_DRAIN: begin
					rd_pend_s1 <= 1'b0;
					state_q    <= ST_FINISH;
				end
				ST_FINISH: begin
					if (job_q.client_ok) begin
						type_q[lane]  <= nx_type;
						count_q[lane] <= nx_count;
						if (clear_row)
							valid_q[lane] <= '0;
						if (add_en)
							valid_q[lane][free_slot_q] <= 1'b1;
						if (rem_en)
							valid_q[lane][found_slot_q] <= 1'b0;
						if (job_q.op == OP_CONNECT)
							conn_q[lane] <= 1'b1;
						if (job_q.op == OP_DISCONNECT)
							conn_q[lane] <= 1'b0;
					end
					done                   <= 1'b1;
					result.match_mask      <= (job_q.op == OP_MATCH) ? mask : '0;
					result.status_type     <= !(job_q.client_ok && nx_type == FT_ACCEPT);
					result.entry_count     <= job_q.client_ok ? count_sat : '0;
					result.prohibited_type <= (job_q.op == OP_PROHIBITED);
					result.beacons_due     <= beacons;
					state_q                <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a result word only follows the finishing step
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FINISH))
		else $error("result strobe without a finishing step");

	// client 0's table never holds more entries than it has slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[0] <= KW'(FILTER_SLOTS))
		else $error("entry count above slot count");

	// beacons are only reported for notify enable
	a_beacons_notify: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.beacons_due) |-> $past(job_q.op == OP_NOTIFY))
		else $error("beacons reported for a command other than notify");

	// a prohibited set never changes the table of its client
	a_prohibited_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && job_q.op == OP_PROHIBITED)
		|-> (!add_en && !rem_en && !clear_row))
		else $error("prohibited set touched a table");

endmodule

FILE: sv/proxy_address_filter_table_unit.sv
// ----------------------------------------------------------------------------
// proxy_address_filter_table_unit: per-client mesh proxy address filters
// Command front end with a two-word queue feeding a table engine.
// ----------------------------------------------------------------------------
//
//  channel   strobe / hold     payload     direction
//  command   start / busy      command     in, taken when start & !busy
//  result    done              result      out, one cycle, cannot stall
//
// Set, connect, disconnect, notify, learn under filter none and commands
// other than relay match for an absent client go straight to finishing;
// the rest walk the table, one table memory row (one slot of every client)
// read per cycle, then drain. Up to two more words queue while one runs;
// busy rises when the queue is full. Reset leaves all tables empty, all
// filters none and all clients disconnected, with no clearing pass.
//
module proxy_address_filter_table_unit
	import pafu_pkg::*;
#(
	parameter int FILTER_SLOTS = FILTER_SLOTS_DEF,
	parameter int CLIENT_COUNT = CLIENT_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cmd_word_t command,
	output logic      busy,
	output logic      done,
	output result_t   result
);

	job_if_t head;
	logic    take;

	// intake and decode
	pafu_front #(
		.CLIENT_COUNT(CLIENT_COUNT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.busy   (busy),
		.head   (head),
		.take   (take)
	);

	// table engine
	pafu_back #(
		.FILTER_SLOTS(FILTER_SLOTS),
		.CLIENT_COUNT(CLIENT_COUNT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.take   (take),
		.done   (done),
		.result (result)
	);

endmodule
